@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the run tracker of the dense run mode detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define DRMD_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define DRMD_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`endif

@@ hw/rtl/drmd_pkg.sv @@
// Shared widths, register codes and inter-stage types of the dense run mode detector.
package drmd_pkg;

  localparam int ROW_W       = 21;
  localparam int RANK_W      = 20;
  localparam int COL_W       = 12;
  localparam int CNT_W       = 13;
  localparam int OFS_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_COLUMNS = 4096;

  // Reset values of the configuration registers.
  localparam logic [ROW_W-1:0] ROW_COUNT_RST       = 21'd1024;
  localparam logic [ROW_W-1:0] DENSE_THRESHOLD_RST = 21'd1048576;
  localparam logic [ROW_W-1:0] ABSENT_RANK_RST     = 21'd1048576;

  // Ordinal reported for a column that is not dense.
  localparam logic [CNT_W-1:0] NOT_DENSE_INDEX = CNT_W'(MAX_COLUMNS);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT       = 2'd0,
    REG_DENSE_THRESHOLD = 2'd1,
    REG_ABSENT_RANK     = 2'd2
  } cfg_reg_t;

  // Current configuration.
  typedef struct packed {
    logic [ROW_W-1:0] row_count;
    logic [ROW_W-1:0] dense_threshold;
    logic [ROW_W-1:0] absent_rank;
  } drmd_cfg_t;

  // Column event from the run tracker: a finished column or a discarded run.
  typedef struct packed {
    logic              overrun;
    logic [COL_W-1:0]  column_index;
    logic [ROW_W-1:0]  best_run;
    logic [RANK_W-1:0] best_rank;
  } drmd_event_t;

  // One result word.
  typedef struct packed {
    logic [COL_W-1:0] column_index;
    logic             is_dense;
    logic [ROW_W-1:0] dense_rank;
    logic [ROW_W-1:0] explicit_count;
    logic [OFS_W-1:0] storage_offset;
    logic [CNT_W-1:0] dense_index;
    logic             overrun;
  } drmd_result_t;

endpackage

@@ hw/rtl/dense_run_mode_detector_unit.sv @@
// Top level of the dense run mode detector: ports, configuration and input register.
//
// Usage:
// Input words (rank, run_length) arrive on in_valid / in_stall, grouped by
// predictor column; the runs of one column add up to row_count. A word is
// taken at a clock edge where in_valid is high and in_stall is low.
// A result word appears on out_valid / out_stall when a column completes
// (its rows reach row_count) or when a run overshoots row_count, in which
// case the run is dropped and overrun is set. Runs that leave the column
// open give no result.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes row_count (0), dense_threshold (1) and absent_rank (2); cfg_ready is
// always high. Write it only while no word is in flight.
// A taken input word passes in order through the input register, the run
// tracker and the decision register. Throughput is one word per cycle while
// in_stall is low, as the run tracker updates its column state for each word.
// When out_stall is high, the output word holds and the upstream stages
// keep filling until the input register is full; then in_stall rises.
// Reset (rst, synchronous) clears all counters and column state and loads
// the configuration registers with their default values.
module dense_run_mode_detector_unit
  import drmd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [RANK_W-1:0]    rank,
  input  logic [ROW_W-1:0]     run_length,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COL_W-1:0]     column_index,
  output logic                 is_dense,
  output logic [ROW_W-1:0]     dense_rank,
  output logic [ROW_W-1:0]     explicit_count,
  output logic [OFS_W-1:0]     storage_offset,
  output logic [CNT_W-1:0]     dense_index,
  output logic                 overrun,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_data
);

  drmd_cfg_t         cfg;
  logic              a_valid;
  logic [RANK_W-1:0] a_rank;
  logic [ROW_W-1:0]  a_len;
  logic              take;
  logic              ev_valid;
  logic              ev_ready;
  drmd_event_t       ev;
  drmd_result_t      result;
  logic              in_fire;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_count       <= ROW_COUNT_RST;
      cfg.dense_threshold <= DENSE_THRESHOLD_RST;
      cfg.absent_rank     <= ABSENT_RANK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_COUNT:       cfg.row_count       <= cfg_data;
        REG_DENSE_THRESHOLD: cfg.dense_threshold <= cfg_data;
        REG_ABSENT_RANK:     cfg.absent_rank     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  assign in_stall = a_valid && !take;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (take) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_rank <= rank;
      a_len  <= run_length;
    end
  end

  drmd_run_tracker u_tracker (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .a_valid  (a_valid),
    .a_rank   (a_rank),
    .a_len    (a_len),
    .take     (take),
    .ev_ready (ev_ready),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  drmd_decision u_decision (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ev_valid  (ev_valid),
    .ev        (ev),
    .ev_ready  (ev_ready),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .result    (result)
  );

  // Output fields.
  assign column_index   = result.column_index;
  assign is_dense       = result.is_dense;
  assign dense_rank     = result.dense_rank;
  assign explicit_count = result.explicit_count;
  assign storage_offset = result.storage_offset;
  assign dense_index    = result.dense_index;
  assign overrun        = result.overrun;

endmodule

@@ hw/rtl/drmd_run_tracker.sv @@
// Run tracker: merges equal-rank runs, keeps the longest one and detects column ends and overruns.
`include "assert_macros.svh"

module drmd_run_tracker
  import drmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  drmd_cfg_t         cfg,
  input  logic              a_valid,
  input  logic [RANK_W-1:0] a_rank,
  input  logic [ROW_W-1:0]  a_len,
  output logic              take,
  input  logic              ev_ready,
  output logic              ev_valid,
  output drmd_event_t       ev
);

  logic [ROW_W-1:0]  rows_seen, rows_seen_next;
  logic              prev_valid, prev_valid_next;
  logic [RANK_W-1:0] prev_rank, prev_rank_next;
  logic [ROW_W-1:0]  merged_run, merged_run_next;
  logic [ROW_W-1:0]  best_run, best_run_next;
  logic [RANK_W-1:0] best_rank, best_rank_next;
  logic [COL_W-1:0]  column_counter, column_counter_next;
  logic              ev_valid_next;
  drmd_event_t       ev_next;

  logic [ROW_W:0]    total;
  logic              over;
  logic              done;
  logic              fire;

  // A new word is taken when the event register is free or drains this cycle.
  assign take = !ev_valid || ev_ready;
  assign fire = a_valid && take;

  // Per-run update of the column state.
  always_comb begin
    total = {1'b0, rows_seen} + {1'b0, a_len};
    over  = total > {1'b0, cfg.row_count};

    if (prev_valid && (a_rank == prev_rank)) begin
      merged_run_next = merged_run + a_len;
    end else begin
      merged_run_next = a_len;
    end
    prev_rank_next  = a_rank;
    prev_valid_next = 1'b1;

    if (merged_run_next > best_run) begin
      best_run_next  = merged_run_next;
      best_rank_next = a_rank;
    end else begin
      best_run_next  = best_run;
      best_rank_next = best_rank;
    end

    rows_seen_next      = total[ROW_W-1:0];
    done                = rows_seen_next == cfg.row_count;
    column_counter_next = column_counter + COL_W'(1);

    ev_next.overrun      = over;
    ev_next.column_index = column_counter;
    ev_next.best_run     = best_run_next;
    ev_next.best_rank    = best_rank_next;

    ev_valid_next = ev_valid && !ev_ready;
    if (fire && (over || done)) begin
      ev_valid_next = 1'b1;
    end
  end

  // Control state: column bookkeeping and the event valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_seen      <= '0;
      prev_valid     <= 1'b0;
      merged_run     <= '0;
      best_run       <= '0;
      column_counter <= '0;
      ev_valid       <= 1'b0;
    end else begin
      ev_valid <= ev_valid_next;
      if (fire && !over) begin
        if (done) begin
          rows_seen      <= '0;
          prev_valid     <= 1'b0;
          merged_run     <= '0;
          best_run       <= '0;
          column_counter <= column_counter_next;
        end else begin
          rows_seen  <= rows_seen_next;
          prev_valid <= prev_valid_next;
          merged_run <= merged_run_next;
          best_run   <= best_run_next;
        end
      end
    end
  end

  // Payload: ranks and the event word.
  always_ff @(posedge clk) begin
    if (fire && !over) begin
      prev_rank <= prev_rank_next;
      best_rank <= best_rank_next;
    end
    if (fire && (over || done)) begin
      ev <= ev_next;
    end
  end

  `DRMD_ASSERT(a_best_within_rows, clk, rst, best_run <= rows_seen, "longest run exceeds rows seen")
  `DRMD_ASSERT(a_merged_within_best, clk, rst, merged_run <= best_run, "merged run exceeds longest run")
  `DRMD_ASSERT(a_fresh_column_empty, clk, rst, !prev_valid |-> (rows_seen == '0), "rows counted with no run open")
  `DRMD_ASSERT(a_overrun_keeps_rows, clk, rst, (fire && over) |=> (rows_seen == $past(rows_seen)), "discarded run changed the row count")

endmodule

@@ hw/rtl/drmd_decision.sv @@
// Column decision: dense test, offsets and ordinals, and the output register.
module drmd_decision
  import drmd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  drmd_cfg_t    cfg,
  input  logic         ev_valid,
  input  drmd_event_t  ev,
  output logic         ev_ready,
  input  logic         out_stall,
  output logic         out_valid,
  output drmd_result_t result
);

  logic [CNT_W-1:0] nondense_counter;
  logic [CNT_W-1:0] dense_counter;
  logic [OFS_W-1:0] compact_accum;
  logic             fire;
  logic             dense;
  logic [ROW_W-1:0] expl;
  drmd_result_t     result_next;

  // The output register takes a new word when it is empty or drains this cycle.
  assign ev_ready = !out_valid || !out_stall;
  assign fire     = ev_valid && ev_ready;

  // Build the result word for the pending event.
  always_comb begin
    dense = ev.best_run > cfg.dense_threshold;
    expl  = cfg.row_count - ev.best_run;

    result_next.column_index = ev.column_index;
    result_next.overrun      = ev.overrun;
    if (ev.overrun) begin
      result_next.is_dense       = 1'b0;
      result_next.dense_rank     = '0;
      result_next.explicit_count = '0;
      result_next.storage_offset = '0;
      result_next.dense_index    = '0;
    end else if (dense) begin
      result_next.is_dense       = 1'b1;
      result_next.dense_rank     = {1'b0, ev.best_rank};
      result_next.explicit_count = expl;
      result_next.storage_offset = compact_accum;
      result_next.dense_index    = dense_counter;
    end else begin
      result_next.is_dense       = 1'b0;
      result_next.dense_rank     = cfg.absent_rank;
      result_next.explicit_count = cfg.row_count;
      result_next.storage_offset = OFS_W'(nondense_counter);
      result_next.dense_index    = NOT_DENSE_INDEX;
    end
  end

  // Counters and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      nondense_counter <= '0;
      dense_counter    <= '0;
      compact_accum    <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (fire && !ev.overrun) begin
        if (dense) begin
          dense_counter <= dense_counter + CNT_W'(1);
          compact_accum <= compact_accum + OFS_W'(expl);
        end else begin
          nondense_counter <= nondense_counter + CNT_W'(1);
        end
      end
    end
  end

  // Output word.
  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

endmodule
